// File: src/qtr_pkg.sv
`default_nettype none
package qtr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ANG_FRAC  = 32;
  localparam int QW        = 18;
  localparam int PW        = 40;
  localparam int TW        = 31;
  localparam int SQW       = 31;
  localparam int RW        = 63;
  localparam int XW        = 51;
  localparam int ZW        = 37;
  localparam int MW        = 48;
  localparam int ROLL_W    = 19;
  localparam int PITCH_W   = 18;
  localparam int NNORM     = 6;
  localparam int NSQ       = 31;
  localparam int TBL_LEN   = 30;
  localparam int RND_SH    = ANG_FRAC - FRAC_BITS;

  localparam logic signed [PW-1:0] ONE_P     = PW'(64'sd1) <<< (2 * FRAC_BITS);
  localparam logic signed [PW-1:0] NEG_ONE_P = -ONE_P;
  localparam logic [RW-1:0]        ONE_SQ    = RW'(1) << 60;

  localparam logic signed [ZW-1:0] PI_Q32     = ZW'(64'sd13493037705);
  localparam logic signed [ZW-1:0] HALF_PI_Q32 = ZW'(64'sd6746518852);
  localparam logic signed [ZW-1:0] RND        = ZW'(64'sd1) <<< (RND_SH - 1);
  localparam logic signed [ZW-1:0] PI_F       = (PI_Q32 + RND) >>> RND_SH;
  localparam logic signed [ZW-1:0] HALF_PI_F  = (HALF_PI_Q32 + RND) >>> RND_SH;

  typedef struct packed {
    logic signed [PW-1:0] roll_y;
    logic signed [PW-1:0] roll_x;
    logic signed [PW-1:0] yaw_y;
    logic signed [PW-1:0] yaw_x;
    logic signed [TW-1:0] t;
    logic                 sat;
    logic                 sat_neg;
  } qtr_side_t;

  typedef struct packed {
    logic [RW-1:0]  rem;
    logic [SQW-1:0] root;
    qtr_side_t      side;
  } qtr_sq_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [MW-1:0]        m;
    logic [1:0]           tag;
  } qtr_lane_t;

  function automatic logic signed [ZW-1:0] atan_q32(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0:       a = ZW'(64'sd3373259426);
      1:       a = ZW'(64'sd1991351318);
      2:       a = ZW'(64'sd1052175346);
      3:       a = ZW'(64'sd534100635);
      4:       a = ZW'(64'sd268086748);
      5:       a = ZW'(64'sd134174063);
      6:       a = ZW'(64'sd67103403);
      7:       a = ZW'(64'sd33553749);
      8:       a = ZW'(64'sd16777131);
      9:       a = ZW'(64'sd8388597);
      10:      a = ZW'(64'sd4194303);
      default: a = (i < TBL_LEN) ? (ZW'(64'sd1) <<< (ANG_FRAC - i)) : '0;
    endcase
    return a;
  endfunction

  function automatic qtr_lane_t make_lane(input logic signed [XW-1:0] y,
                                          input logic signed [XW-1:0] x,
                                          input logic [1:0] tag);
    qtr_lane_t l;
    logic [XW-1:0] ax;
    logic [XW-1:0] ay;
    ax = x[XW-1] ? XW'(-x) : XW'(x);
    ay = y[XW-1] ? XW'(-y) : XW'(y);
    l.x = x;
    l.y = y;
    l.z = '0;
    l.m = (ax > ay) ? MW'(ax) : MW'(ay);
    l.tag = tag;
    return l;
  endfunction

endpackage
`default_nettype wire

// File: src/qtr_if.sv
`default_nettype none
interface qtr_in_if;
  import qtr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [QW-1:0] quat_x;
  logic signed [QW-1:0] quat_y;
  logic signed [QW-1:0] quat_z;
  logic signed [QW-1:0] quat_w;
  modport source(output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink(input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface qtr_out_if;
  import qtr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [ROLL_W-1:0]  roll_angle;
  logic signed [PITCH_W-1:0] pitch_angle;
  logic signed [ROLL_W-1:0]  yaw_angle;
  logic                      pitch_clamped;
  modport source(output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                 input ready);
  modport sink(input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
               output ready);
endinterface
`default_nettype wire

// File: src/qtr_sqrt_cell.sv
`default_nettype none
module qtr_sqrt_cell #(
  parameter int BIT = 30
) (
  input  logic             clk,
  input  logic             en,
  input  qtr_pkg::qtr_sq_t d_i,
  output qtr_pkg::qtr_sq_t d_o
);
  import qtr_pkg::*;

  qtr_sq_t       d_r;
  qtr_sq_t       d_nxt;
  logic [RW-1:0] trial;

  always_comb begin
    trial = (RW'(d_i.root) << (BIT + 1)) + (RW'(1) << (2 * BIT));
    d_nxt = d_i;
    if (d_i.rem >= trial) begin
      d_nxt.rem  = d_i.rem - trial;
      d_nxt.root = d_i.root | (SQW'(1) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;
endmodule
`default_nettype wire

// File: src/qtr_norm_cell.sv
`default_nettype none
module qtr_norm_cell #(
  parameter int SH   = 32,
  parameter bit LAST = 1'b0
) (
  input  logic               clk,
  input  logic               en,
  input  qtr_pkg::qtr_lane_t d_i,
  output qtr_pkg::qtr_lane_t d_o
);
  import qtr_pkg::*;

  qtr_lane_t d_r;
  qtr_lane_t d_nxt;
  qtr_lane_t s;

  always_comb begin
    s = d_i;
    // top bits clear: shift up toward the normalized position
    if (d_i.m[MW-2 -: SH] == '0) begin
      s.x = d_i.x <<< SH;
      s.y = d_i.y <<< SH;
      s.m = d_i.m << SH;
    end
    d_nxt = s;
    if (LAST && s.x[XW-1]) begin
      d_nxt.z = s.y[XW-1] ? -PI_Q32 : PI_Q32;
      d_nxt.x = -s.x;
      d_nxt.y = -s.y;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;
endmodule
`default_nettype wire

// File: src/qtr_cordic_cell.sv
`default_nettype none
module qtr_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               en,
  input  qtr_pkg::qtr_lane_t d_i,
  output qtr_pkg::qtr_lane_t d_o
);
  import qtr_pkg::*;

  localparam logic signed [ZW-1:0] ANG = atan_q32(IDX);

  qtr_lane_t            d_r;
  qtr_lane_t            d_nxt;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;

  always_comb begin
    xs    = d_i.x >>> IDX;
    ys    = d_i.y >>> IDX;
    d_nxt = d_i;
    if (!d_i.y[XW-1]) begin
      d_nxt.x = d_i.x + ys;
      d_nxt.y = d_i.y - xs;
      d_nxt.z = d_i.z + ANG;
    end else begin
      d_nxt.x = d_i.x - ys;
      d_nxt.y = d_i.y + xs;
      d_nxt.z = d_i.z - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;
endmodule
`default_nettype wire

// File: src/quaternion_to_rpy.sv
`default_nettype none
// Quaternion (x, y, z, w, signed Q2.16) to ZYX roll, pitch and yaw in radians (roll and
// yaw signed Q3.16, pitch signed Q2.16). Fully pipelined: one request is taken every
// cycle while the result side does not stall. The pipeline holds four product/sum
// stages, a 31-cell square-root chain for the pitch cosine, a 6-cell normalizer,
// N = min(CORDIC_STAGES, 30) CORDIC cells per angle and the output register. A stall on
// the result side freezes the whole pipeline. pitch_clamped flags a sine term of
// magnitude one or more, where pitch is held at plus or minus pi/2.
module quaternion_to_rpy #(
  parameter int CORDIC_STAGES = 18
) (
  input  logic            clk,
  input  logic            rst_n,
  qtr_in_if.sink          in_req,
  qtr_out_if.source       out_req
);
  import qtr_pkg::*;

  localparam int NS   = (CORDIC_STAGES > TBL_LEN) ? TBL_LEN : CORDIC_STAGES;
  localparam int NTOT = 4 + NSQ + NNORM + NS;

  logic            en;
  logic [NTOT-1:0] vld_r;
  logic            out_valid_r;

  assign en           = !out_valid_r || out_req.ready;
  assign in_req.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NTOT-2:0], in_req.valid};
      out_valid_r <= vld_r[NTOT-1];
    end
  end

  // products
  logic signed [2*QW-1:0] xx_r, yy_r, zz_r, wx_r, yz_r, wz_r, xy_r, wy_r, zx_r;
  always_ff @(posedge clk) begin
    if (en) begin
      xx_r <= (2*QW)'(in_req.quat_x) * (2*QW)'(in_req.quat_x);
      yy_r <= (2*QW)'(in_req.quat_y) * (2*QW)'(in_req.quat_y);
      zz_r <= (2*QW)'(in_req.quat_z) * (2*QW)'(in_req.quat_z);
      wx_r <= (2*QW)'(in_req.quat_w) * (2*QW)'(in_req.quat_x);
      yz_r <= (2*QW)'(in_req.quat_y) * (2*QW)'(in_req.quat_z);
      wz_r <= (2*QW)'(in_req.quat_w) * (2*QW)'(in_req.quat_z);
      xy_r <= (2*QW)'(in_req.quat_x) * (2*QW)'(in_req.quat_y);
      wy_r <= (2*QW)'(in_req.quat_w) * (2*QW)'(in_req.quat_y);
      zx_r <= (2*QW)'(in_req.quat_z) * (2*QW)'(in_req.quat_x);
    end
  end

  // sums
  logic signed [PW-1:0] sr_r, cr_r, sy_r, cy_r, sp_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sr_r <= (PW'(wx_r) + PW'(yz_r)) <<< 1;
      cr_r <= ONE_P - ((PW'(xx_r) + PW'(yy_r)) <<< 1);
      sy_r <= (PW'(wz_r) + PW'(xy_r)) <<< 1;
      cy_r <= ONE_P - ((PW'(yy_r) + PW'(zz_r)) <<< 1);
      sp_r <= (PW'(wy_r) - PW'(zx_r)) <<< 1;
    end
  end

  // sine term, its magnitude, then its square
  qtr_side_t            s3_r;
  qtr_side_t            s4_r;
  qtr_side_t            s3_nxt;
  logic [SQW-1:0]       tm_r;
  logic [2*SQW-1:0]     sq_r;
  logic signed [PW-1:0] sp_sh;

  always_comb begin
    sp_sh          = sp_r >>> (2 * FRAC_BITS - 30);
    s3_nxt.roll_y  = sr_r;
    s3_nxt.roll_x  = cr_r;
    s3_nxt.yaw_y   = sy_r;
    s3_nxt.yaw_x   = cy_r;
    s3_nxt.t       = TW'(sp_sh);
    s3_nxt.sat     = sp_r >= ONE_P;
    s3_nxt.sat_neg = sp_r <= NEG_ONE_P;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r <= s3_nxt;
      tm_r <= s3_nxt.t[TW-1] ? SQW'(-s3_nxt.t) : SQW'(s3_nxt.t);
      s4_r <= s3_r;
      sq_r <= (2*SQW)'(tm_r) * (2*SQW)'(tm_r);
    end
  end

  // square-root chain for the cosine
  qtr_sq_t sq_c [NSQ+1];
  assign sq_c[0].rem  = ONE_SQ - RW'(sq_r);
  assign sq_c[0].root = '0;
  assign sq_c[0].side = s4_r;

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    qtr_sqrt_cell #(.BIT(NSQ - 1 - k)) u_cell (
      .clk(clk), .en(en), .d_i(sq_c[k]), .d_o(sq_c[k+1])
    );
  end

  qtr_side_t sd;
  assign sd = sq_c[NSQ].side;

  // lanes: 0 roll, 1 pitch, 2 yaw
  qtr_lane_t nl [3][NNORM+1];
  qtr_lane_t cl [3][NS+1];

  assign nl[0][0] = make_lane(XW'(sd.roll_y), XW'(sd.roll_x), 2'b00);
  assign nl[1][0] = make_lane(XW'(sd.t), XW'({1'b0, sq_c[NSQ].root}),
                              {sd.sat, sd.sat_neg});
  assign nl[2][0] = make_lane(XW'(sd.yaw_y), XW'(sd.yaw_x), 2'b00);

  for (genvar l = 0; l < 3; l++) begin : g_lane
    for (genvar k = 0; k < NNORM; k++) begin : g_norm
      qtr_norm_cell #(.SH(32 >> k), .LAST(k == NNORM - 1)) u_cell (
        .clk(clk), .en(en), .d_i(nl[l][k]), .d_o(nl[l][k+1])
      );
    end
    assign cl[l][0] = nl[l][NNORM];
    for (genvar k = 0; k < NS; k++) begin : g_cordic
      qtr_cordic_cell #(.IDX(k)) u_cell (
        .clk(clk), .en(en), .d_i(cl[l][k]), .d_o(cl[l][k+1])
      );
    end
  end

  // rounding and clamping
  function automatic logic signed [ZW-1:0] fin(input qtr_lane_t l,
                                               input logic signed [ZW-1:0] lim);
    logic signed [ZW-1:0] r;
    r = (l.z + RND) >>> RND_SH;
    if (l.m == '0) begin
      r = '0;
    end else if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  logic signed [ZW-1:0]      roll_f, pitch_f, yaw_f;
  logic signed [PITCH_W-1:0] pitch_sel;
  qtr_lane_t                 pl;

  always_comb begin
    pl      = cl[1][NS];
    roll_f  = fin(cl[0][NS], PI_F);
    yaw_f   = fin(cl[2][NS], PI_F);
    pitch_f = fin(pl, HALF_PI_F);
    if (pl.tag[1]) begin
      pitch_sel = PITCH_W'(HALF_PI_F);
    end else if (pl.tag[0]) begin
      pitch_sel = PITCH_W'(-HALF_PI_F);
    end else begin
      pitch_sel = PITCH_W'(pitch_f);
    end
  end

  logic signed [ROLL_W-1:0]  roll_r, yaw_r;
  logic signed [PITCH_W-1:0] pitch_r;
  logic                      clamp_r;

  always_ff @(posedge clk) begin
    if (en) begin
      roll_r  <= ROLL_W'(roll_f);
      yaw_r   <= ROLL_W'(yaw_f);
      pitch_r <= pitch_sel;
      clamp_r <= pl.tag[1] | pl.tag[0];
    end
  end

  assign out_req.valid         = out_valid_r;
  assign out_req.roll_angle    = roll_r;
  assign out_req.pitch_angle   = pitch_r;
  assign out_req.yaw_angle     = yaw_r;
  assign out_req.pitch_clamped = clamp_r;
endmodule
`default_nettype wire
